FILE: rtl/ipmg_pkg.sv
package ipmg_pkg;

    // Power modes
    localparam logic [1:0] MODE_ACTIVE = 2'd0;
    localparam logic [1:0] MODE_IDLE   = 2'd1;
    localparam logic [1:0] MODE_SLEEP  = 2'd2;
    localparam logic [1:0] MODE_DEEP   = 2'd3;

    // Event opcodes
    localparam logic [1:0] OP_ACTIVITY = 2'd0;
    localparam logic [1:0] OP_CONNECT  = 2'd1;
    localparam logic [1:0] OP_LOST     = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_IDLE_AFTER  = 3'd0;
    localparam logic [2:0] REG_SLEEP_AFTER = 3'd1;
    localparam logic [2:0] REG_DEEP_AFTER  = 3'd2;
    localparam logic [2:0] REG_DRAIN_PER   = 3'd3;
    localparam logic [2:0] REG_LOW_BATT    = 3'd4;
    localparam logic [2:0] REG_ACTIVE_TICK = 3'd5;
    localparam logic [2:0] REG_IDLE_TICK   = 3'd6;
    localparam logic [2:0] REG_SLEEP_TICK  = 3'd7;

    // Register reset values
    localparam logic [31:0] RST_IDLE_AFTER  = 32'd5000;
    localparam logic [31:0] RST_SLEEP_AFTER = 32'd30000;
    localparam logic [31:0] RST_DEEP_AFTER  = 32'd120000;
    localparam logic [31:0] RST_DRAIN_PER   = 32'd60000;
    localparam logic [6:0]  RST_LOW_BATT    = 7'd15;
    localparam logic [31:0] RST_ACTIVE_TICK = 32'd3000;
    localparam logic [31:0] RST_IDLE_TICK   = 32'd8000;
    localparam logic [31:0] RST_SLEEP_TICK  = 32'd20000;

    localparam logic [6:0] BATT_FULL = 7'd100;
    localparam logic [1:0] DRAIN_STEP = 2'd2;

    typedef struct packed {
        logic [31:0] idle_after_ms;
        logic [31:0] sleep_after_ms;
        logic [31:0] deep_after_ms;
        logic [31:0] drain_period_ms;
        logic [6:0]  low_batt_pct;
        logic [31:0] active_tick_ms;
        logic [31:0] idle_tick_ms;
        logic [31:0] sleep_tick_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        central_linked;
        logic        peripheral_linked;
    } t_evt;

    typedef struct packed {
        logic [1:0]  mode;
        logic        params_valid;
        logic [8:0]  conn_itv_min;
        logic [8:0]  conn_itv_max;
        logic [3:0]  slave_latency;
        logic [10:0] supervision_timeout;
        logic        rssi_due;
        logic [31:0] next_period_ms;
        logic [6:0]  batt_pct;
        logic        low_power_latched;
        logic [31:0] active_total_ms;
        logic [31:0] sleep_total_ms;
    } t_res;

    typedef struct packed {
        logic [8:0]  imin;
        logic [8:0]  imax;
        logic [3:0]  lat;
        logic [10:0] tmo;
    } t_link;

    function automatic t_link link_params(input logic [1:0] m);
        t_link p;
        case (m)
            MODE_ACTIVE: p = '{imin: 9'd6,   imax: 9'd12,  lat: 4'd0,  tmo: 11'd400};
            MODE_IDLE:   p = '{imin: 9'd40,  imax: 9'd60,  lat: 4'd1,  tmo: 11'd600};
            MODE_SLEEP:  p = '{imin: 9'd80,  imax: 9'd120, lat: 4'd4,  tmo: 11'd800};
            default:     p = '{imin: 9'd240, imax: 9'd320, lat: 4'd10, tmo: 11'd1200};
        endcase
        return p;
    endfunction

    function automatic logic [1:0] drain_weight(input logic [1:0] m);
        logic [1:0] r;
        case (m)
            MODE_ACTIVE: r = 2'd2;
            MODE_IDLE:   r = 2'd1;
            default:     r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ipmg_ifs.sv
interface ipmg_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic        central_linked;
    logic        peripheral_linked;

    modport source (output valid, opcode, now_ms, central_linked, peripheral_linked,
                    input ready);
    modport sink (input valid, opcode, now_ms, central_linked, peripheral_linked,
                  output ready);
endinterface

interface ipmg_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        params_valid;
    logic [8:0]  conn_itv_min;
    logic [8:0]  conn_itv_max;
    logic [3:0]  slave_latency;
    logic [10:0] supervision_timeout;
    logic        rssi_due;
    logic [31:0] next_period_ms;
    logic [6:0]  batt_pct;
    logic        low_power_latched;
    logic [31:0] active_total_ms;
    logic [31:0] sleep_total_ms;

    modport source (output valid, mode, params_valid, conn_itv_min, conn_itv_max,
                    slave_latency, supervision_timeout, rssi_due, next_period_ms,
                    batt_pct, low_power_latched, active_total_ms, sleep_total_ms,
                    input ready);
    modport sink (input valid, mode, params_valid, conn_itv_min, conn_itv_max,
                  slave_latency, supervision_timeout, rssi_due, next_period_ms,
                  batt_pct, low_power_latched, active_total_ms, sleep_total_ms,
                  output ready);
endinterface

FILE: rtl/ipmg_regs.sv
module ipmg_regs import ipmg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_after_ms   <= RST_IDLE_AFTER;
            r_cfg.sleep_after_ms  <= RST_SLEEP_AFTER;
            r_cfg.deep_after_ms   <= RST_DEEP_AFTER;
            r_cfg.drain_period_ms <= RST_DRAIN_PER;
            r_cfg.low_batt_pct    <= RST_LOW_BATT;
            r_cfg.active_tick_ms  <= RST_ACTIVE_TICK;
            r_cfg.idle_tick_ms    <= RST_IDLE_TICK;
            r_cfg.sleep_tick_ms   <= RST_SLEEP_TICK;
        end else if (wr) begin
            case (idx)
                REG_IDLE_AFTER:  r_cfg.idle_after_ms   <= pwdata;
                REG_SLEEP_AFTER: r_cfg.sleep_after_ms  <= pwdata;
                REG_DEEP_AFTER:  r_cfg.deep_after_ms   <= pwdata;
                REG_DRAIN_PER:   r_cfg.drain_period_ms <= pwdata;
                REG_LOW_BATT:    r_cfg.low_batt_pct    <= pwdata[6:0];
                REG_ACTIVE_TICK: r_cfg.active_tick_ms  <= pwdata;
                REG_IDLE_TICK:   r_cfg.idle_tick_ms    <= pwdata;
                REG_SLEEP_TICK:  r_cfg.sleep_tick_ms   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_IDLE_AFTER:  prdata = r_cfg.idle_after_ms;
            REG_SLEEP_AFTER: prdata = r_cfg.sleep_after_ms;
            REG_DEEP_AFTER:  prdata = r_cfg.deep_after_ms;
            REG_DRAIN_PER:   prdata = r_cfg.drain_period_ms;
            REG_LOW_BATT:    prdata = {25'd0, r_cfg.low_batt_pct};
            REG_ACTIVE_TICK: prdata = r_cfg.active_tick_ms;
            REG_IDLE_TICK:   prdata = r_cfg.idle_tick_ms;
            REG_SLEEP_TICK:  prdata = r_cfg.sleep_tick_ms;
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/ipmg_core.sv
module ipmg_core import ipmg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_evt i_evt,
    input  t_cfg i_cfg,
    output t_res o_res
);

    logic [1:0]  r_mode, n_mode;
    logic [31:0] r_act_stamp, n_act_stamp;
    logic [31:0] r_mode_stamp, n_mode_stamp;
    logic [31:0] r_drain_stamp, n_drain_stamp;
    logic [1:0]  r_drain_cnt, n_drain_cnt;
    logic [6:0]  r_batt, n_batt;
    logic        r_latch, n_latch;
    logic [31:0] r_act_time, n_act_time;
    logic [31:0] r_slp_time, n_slp_time;
    t_res        r_res, n_res;

    logic [1:0]  target;
    logic        is_tick;
    logic        force_params;
    logic        forced;
    logic        linked;
    logic        changed;
    logic        params;
    logic [31:0] idle;
    logic [31:0] spent;
    logic [1:0]  cnt_sum;
    t_link       link;

    assign linked = i_evt.central_linked || i_evt.peripheral_linked;
    assign o_res  = r_res;

    always_comb begin
        n_mode        = r_mode;
        n_act_stamp   = r_act_stamp;
        n_mode_stamp  = r_mode_stamp;
        n_drain_stamp = r_drain_stamp;
        n_drain_cnt   = r_drain_cnt;
        n_batt        = r_batt;
        n_latch       = r_latch;
        n_act_time    = r_act_time;
        n_slp_time    = r_slp_time;
        target        = r_mode;
        is_tick       = 1'b0;
        force_params  = 1'b0;
        forced        = 1'b0;
        idle          = i_evt.now_ms - r_act_stamp;
        cnt_sum       = 2'(r_drain_cnt + drain_weight(r_mode));

        case (i_evt.opcode)
            OP_ACTIVITY, OP_CONNECT: begin
                n_act_stamp  = i_evt.now_ms;
                target       = MODE_ACTIVE;
                force_params = (i_evt.opcode == OP_CONNECT);
            end
            OP_LOST: begin
                target = MODE_SLEEP;
            end
            default: begin
                is_tick = 1'b1;
                // drain evaluation, once per period
                if ((i_evt.now_ms - r_drain_stamp) > i_cfg.drain_period_ms) begin
                    if (cnt_sum >= DRAIN_STEP) begin
                        n_batt      = (r_batt == 7'd0) ? 7'd0 : 7'(r_batt - 7'd1);
                        n_drain_cnt = 2'd0;
                    end else begin
                        n_drain_cnt = cnt_sum;
                    end
                    n_drain_stamp = i_evt.now_ms;
                    if ((n_batt <= i_cfg.low_batt_pct) && !r_latch) begin
                        n_latch = 1'b1;
                        target  = MODE_DEEP;
                        forced  = 1'b1;
                    end
                end
                if (!forced && !r_latch) begin
                    if (idle > i_cfg.deep_after_ms) begin
                        target = MODE_DEEP;
                    end else if (idle > i_cfg.sleep_after_ms) begin
                        target = MODE_SLEEP;
                    end else if (idle > i_cfg.idle_after_ms) begin
                        target = MODE_IDLE;
                    end else begin
                        target = MODE_ACTIVE;
                    end
                end
            end
        endcase

        // charge elapsed time to the mode being left
        changed = (target != r_mode);
        spent   = i_evt.now_ms - r_mode_stamp;
        if (changed) begin
            if (r_mode == MODE_ACTIVE) begin
                n_act_time = r_act_time + spent;
            end else begin
                n_slp_time = r_slp_time + spent;
            end
            n_mode       = target;
            n_mode_stamp = i_evt.now_ms;
        end

        params = (changed && linked) || force_params;
        link   = link_params(n_mode);

        n_res.mode                = n_mode;
        n_res.params_valid        = params;
        n_res.conn_itv_min        = params ? link.imin : '0;
        n_res.conn_itv_max        = params ? link.imax : '0;
        n_res.slave_latency       = params ? link.lat  : '0;
        n_res.supervision_timeout = params ? link.tmo  : '0;
        n_res.rssi_due            = is_tick && (n_mode != MODE_DEEP);
        n_res.batt_pct            = n_batt;
        n_res.low_power_latched   = n_latch;
        n_res.active_total_ms     = n_act_time;
        n_res.sleep_total_ms      = n_slp_time;
        if (!is_tick) begin
            n_res.next_period_ms = '0;
        end else begin
            case (n_mode)
                MODE_ACTIVE: n_res.next_period_ms = i_cfg.active_tick_ms;
                MODE_IDLE:   n_res.next_period_ms = i_cfg.idle_tick_ms;
                MODE_SLEEP:  n_res.next_period_ms = i_cfg.sleep_tick_ms;
                default:     n_res.next_period_ms = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ACTIVE;
            r_act_stamp   <= '0;
            r_mode_stamp  <= '0;
            r_drain_stamp <= '0;
            r_drain_cnt   <= '0;
            r_batt        <= BATT_FULL;
            r_latch       <= 1'b0;
            r_act_time    <= '0;
            r_slp_time    <= '0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_act_stamp   <= n_act_stamp;
            r_mode_stamp  <= n_mode_stamp;
            r_drain_stamp <= n_drain_stamp;
            r_drain_cnt   <= n_drain_cnt;
            r_batt        <= n_batt;
            r_latch       <= n_latch;
            r_act_time    <= n_act_time;
            r_slp_time    <= n_slp_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: rtl/idle_power_mode_governor.sv
// Channel   Dir  Role    Word
// i_evt     in   sink    opcode, now_ms, central_linked, peripheral_linked
// o_res     out  source  mode, link parameters, tick period, battery and time totals
// apb       in   slave   eight 32-bit registers at byte address 4*index
//
// One word per cycle sustained while results are accepted. A word taken sits in the
// input register and is stepped into the result register once the result slot is
// empty or being drained, and its result is then offered on o_res. The governor
// state is updated in the same cycle as the result.
// Reset is synchronous, active low, and restores every APB register and the state,
// but not the input and result words. A stalled result holds the step; the input
// register keeps taking words while it is empty or moving into the result register.
module idle_power_mode_governor import ipmg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipmg_evt_if.sink    i_evt,
    ipmg_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_evt r_in;
    t_res res;
    logic r_in_vld, n_in_vld;
    logic r_out_vld, n_out_vld;
    logic adv;
    logic step;
    logic take;

    ipmg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // advance the result slot when it is empty or being drained
    assign adv         = !r_out_vld || o_res.ready;
    assign step        = r_in_vld && adv;
    assign i_evt.ready = !r_in_vld || step;
    assign take        = i_evt.valid && i_evt.ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (take) begin
            n_in_vld = 1'b1;
        end else if (step) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (step) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // capture the incoming word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.opcode            <= i_evt.opcode;
            r_in.now_ms            <= i_evt.now_ms;
            r_in.central_linked    <= i_evt.central_linked;
            r_in.peripheral_linked <= i_evt.peripheral_linked;
        end
    end

    ipmg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_evt   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_res.valid               = r_out_vld;
    assign o_res.mode                = res.mode;
    assign o_res.params_valid        = res.params_valid;
    assign o_res.conn_itv_min        = res.conn_itv_min;
    assign o_res.conn_itv_max        = res.conn_itv_max;
    assign o_res.slave_latency       = res.slave_latency;
    assign o_res.supervision_timeout = res.supervision_timeout;
    assign o_res.rssi_due            = res.rssi_due;
    assign o_res.next_period_ms      = res.next_period_ms;
    assign o_res.batt_pct            = res.batt_pct;
    assign o_res.low_power_latched   = res.low_power_latched;
    assign o_res.active_total_ms     = res.active_total_ms;
    assign o_res.sleep_total_ms      = res.sleep_total_ms;

endmodule
